// File: hw/rtl/hsfd_pkg.sv
// Shared types and constants for the humidity sensor frame decoder.
// Used by the front end, the frame queue, the scaling back end and the top level.
package hsfd_pkg;

    // CRC-8 of the sensor: polynomial 0x31, initial value 0xFF, MSB first.
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Byte positions within the six-byte measurement frame.
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Scaling constants, in hundredths.
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUMI_SCALE  = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

    // Default depth of the queue between front and back end.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_CRC = 2'd1,
        ST_HUMI_CRC = 2'd2
    } t_status;

    // One checked frame, handed from the front end to the back end.
    typedef struct packed {
        t_status     status;
        logic [15:0] raw_t;
        logic [15:0] raw_h;
    } t_frame_rec;

    // One CRC-8 update over a byte, bit by bit.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

// File: hw/rtl/hsfd_front.sv
// Front end of the frame decoder: tracks byte position, runs the CRC checks
// and assembles the raw words. Depends on hsfd_pkg.
module hsfd_front import hsfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_start,
    input  logic       i_queue_full,
    output logic       o_byte_ready,
    output logic       o_push,
    output t_frame_rec o_rec
);

    logic [2:0]  r_pos,       n_pos;
    logic [7:0]  r_crc,       n_crc;
    logic [15:0] r_temp_word, n_temp_word;
    logic [15:0] r_humi_word, n_humi_word;
    logic        r_temp_bad,  n_temp_bad;

    logic       w_accept;
    logic [2:0] w_pos;

    // A byte is taken whenever the queue has room for a possible frame.
    assign o_byte_ready = !i_queue_full;
    assign w_accept     = i_byte_valid && !i_queue_full;

    // Frame start forces position zero; unused positions also restart.
    always_comb begin
        if (i_frame_start || (r_pos > POS_H_CRC)) begin
            w_pos = POS_T_HI;
        end else begin
            w_pos = r_pos;
        end
    end

    // Next-state update for the byte being accepted.
    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_temp_word = r_temp_word;
        n_humi_word = r_humi_word;
        n_temp_bad  = r_temp_bad;
        if (w_accept) begin
            unique case (w_pos)
                POS_T_HI: begin
                    n_crc       = crc8_byte(CRC_INIT, i_data_byte);
                    n_temp_word = {i_data_byte, 8'h00};
                    n_pos       = POS_T_LO;
                end
                POS_T_LO: begin
                    n_crc       = crc8_byte(r_crc, i_data_byte);
                    n_temp_word = {r_temp_word[15:8], i_data_byte};
                    n_pos       = POS_T_CRC;
                end
                POS_T_CRC: begin
                    n_temp_bad = (r_crc != i_data_byte);
                    n_crc      = CRC_INIT;
                    n_pos      = POS_H_HI;
                end
                POS_H_HI: begin
                    n_crc       = crc8_byte(CRC_INIT, i_data_byte);
                    n_humi_word = {i_data_byte, 8'h00};
                    n_pos       = POS_H_LO;
                end
                POS_H_LO: begin
                    n_crc       = crc8_byte(r_crc, i_data_byte);
                    n_humi_word = {r_humi_word[15:8], i_data_byte};
                    n_pos       = POS_H_CRC;
                end
                default: begin
                    n_crc = CRC_INIT;
                    n_pos = POS_T_HI;
                end
            endcase
        end
    end

    // The last byte of a frame pushes a record with its status.
    assign o_push = w_accept && (w_pos == POS_H_CRC);

    always_comb begin
        o_rec.raw_t = r_temp_word;
        o_rec.raw_h = r_humi_word;
        priority if (r_temp_bad) begin
            o_rec.status = ST_TEMP_CRC;
        end else if (r_crc != i_data_byte) begin
            o_rec.status = ST_HUMI_CRC;
        end else begin
            o_rec.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_T_HI;
            r_crc       <= CRC_INIT;
            r_temp_word <= '0;
            r_humi_word <= '0;
            r_temp_bad  <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_temp_word <= n_temp_word;
            r_humi_word <= n_humi_word;
            r_temp_bad  <= n_temp_bad;
        end
    end

endmodule

// File: hw/rtl/hsfd_fifo.sv
// Short register queue of checked frames between front and back end.
// Depends on hsfd_pkg for the frame record type.
module hsfd_fifo import hsfd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    input  logic       i_pop,
    output t_frame_rec o_rec,
    output logic       o_empty,
    output logic       o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame_rec    r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          w_wr, w_rd;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_rec   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// File: hw/rtl/hsfd_scale.sv
// Back end of the frame decoder: scales the raw words to hundredths in a
// multiply stage and a quotient estimate stage that feed an output register.
// Depends on hsfd_pkg.
module hsfd_scale import hsfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_rec  i_rec,
    input  logic        i_rec_valid,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data
);

    localparam int PROD_W = 31;

    // Estimate of floor(p / 65535), never above the exact quotient.
    function automatic logic [14:0] div_est(input logic [PROD_W-1:0] p);
        logic [31:0] sum;
        sum = 32'(p) + 32'(p[PROD_W-1:16]);
        return sum[30:16];
    endfunction

    // One correction step: the estimate is at most one below the quotient.
    function automatic logic [14:0] div_fix(input logic [PROD_W-1:0] p,
                                            input logic [14:0] q0);
        logic [31:0] rem;
        rem = 32'(p) + 32'(q0) - {1'b0, q0, 16'h0000};
        return (rem >= 32'(FULL_SCALE)) ? q0 + 1'b1 : q0;
    endfunction

    logic              w_adv;
    logic              r_s1_valid;
    t_status           r_s1_status;
    logic [PROD_W-1:0] r_s1_prod_t, r_s1_prod_h;
    logic              r_s2_valid;
    t_status           r_s2_status;
    logic [PROD_W-1:0] r_s2_prod_t, r_s2_prod_h;
    logic [14:0]       r_s2_q0_t,   r_s2_q0_h;
    logic              r_out_valid;
    logic [31:0]       r_out_data,  n_out_data;
    logic [14:0]       w_q_t,       w_q_h;

    // The pipeline moves when the output register is free or being taken.
    assign w_adv   = !r_out_valid || i_ready;
    assign o_pop   = w_adv && i_rec_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // Final quotients, offset and packing of the result.
    always_comb begin
        w_q_t = div_fix(r_s2_prod_t, r_s2_q0_t);
        w_q_h = div_fix(r_s2_prod_h, r_s2_q0_h);
        if (r_s2_status == ST_OK) begin
            n_out_data = {1'b0, w_q_h[13:0], w_q_t - TEMP_OFFSET, r_s2_status};
        end else begin
            n_out_data = {1'b0, 14'd0, 15'd0, r_s2_status};
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_rec_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Stage payloads: multiply, estimate, correct.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_status <= i_rec.status;
            r_s1_prod_t <= PROD_W'(i_rec.raw_t) * PROD_W'(TEMP_SCALE);
            r_s1_prod_h <= PROD_W'(i_rec.raw_h) * PROD_W'(HUMI_SCALE);
            r_s2_status <= r_s1_status;
            r_s2_prod_t <= r_s1_prod_t;
            r_s2_prod_h <= r_s1_prod_h;
            r_s2_q0_t   <= div_est(r_s1_prod_t);
            r_s2_q0_h   <= div_est(r_s1_prod_h);
            r_out_data  <= n_out_data;
        end
    end

endmodule

// File: hw/rtl/humidity_sensor_frame_decode.sv
// Top level of the humidity sensor frame decoder.
// Depends on hsfd_pkg, hsfd_front, hsfd_fifo and hsfd_scale.
//
// Usage:
//   The slave channel takes one byte of the six-byte measurement frame per
//   transaction: tdata carries the byte, tuser marks the first byte of a frame
//   and resets the byte position. Frames are temperature word, its CRC,
//   humidity word, its CRC. The sixth byte of a frame yields one transaction
//   on the master channel with the status, the temperature in hundredths of a
//   degree and the humidity in hundredths of a percent (values zero on a CRC
//   mismatch); other bytes yield none.
//   Throughput is one byte per cycle while the frame queue is not full. The
//   sixth byte of a frame is written into the frame queue, then passes the
//   multiply stage and the quotient estimate stage, whose corrected quotient
//   is loaded into the output register that drives the master channel.
//   When the receiver stalls, the scaling pipeline holds, the frame queue
//   fills and s_axis_tready drops once the queue is full.
//   Reset clears the byte position, the CRC state, the queue and all valid
//   flags; the block is ready for a byte as soon as reset is released.
module humidity_sensor_frame_decode import hsfd_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [1:0] status, [16:2] temperature_centi,
                                       // [30:17] humidity_centi, [31] zero
);

    logic       w_push;
    logic       w_pop;
    logic       w_empty;
    logic       w_full;
    t_frame_rec w_front_rec;
    t_frame_rec w_queue_rec;

    // Position tracking and CRC checks.
    hsfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (s_axis_tvalid),
        .i_data_byte   (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_queue_full  (w_full),
        .o_byte_ready  (s_axis_tready),
        .o_push        (w_push),
        .o_rec         (w_front_rec)
    );

    // Queue of checked frames.
    hsfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_front_rec),
        .i_pop   (w_pop),
        .o_rec   (w_queue_rec),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // Scaling pipeline and output register.
    hsfd_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (w_queue_rec),
        .i_rec_valid (!w_empty),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // A failed check always reports zero values.
    a_bad_crc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK))
            |-> (m_axis_tdata[30:2] == 29'd0))
        else $error("nonzero values on a CRC mismatch");

    // Scaled values stay within the sensor range.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[30:17] <= 14'd10000)
            && ($signed(m_axis_tdata[16:2]) >= -15'sd4500)
            && ($signed(m_axis_tdata[16:2]) <= 15'sd13000)
            && (m_axis_tdata[1:0] != 2'd3)))
        else $error("result out of range");

    // A frame is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("frame pushed into full queue");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for humidity_sensor_frame_decode: streams measurement frames and
// compares each decoded reading with a bit-accurate model kept in a scoreboard class.
// Depends on hsfd_pkg and the RTL of the decoder.
module tb;
    import hsfd_pkg::*;

    localparam int TARGET_BYTES = 1100;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 24;

    // One decoded reading as it should appear on the master channel.
    typedef struct {
        t_status     status;
        logic [14:0] temp_centi;
        logic [13:0] humi_centi;
    } t_reading;

    // Tracks the frame state and holds the readings still owed by the decoder.
    class reading_board;
        t_reading    pending_readings[$];
        int          errors;
        bit [2:0]    byte_pos;
        bit [7:0]    crc_acc;
        bit [15:0]   temp_word;
        bit [15:0]   humi_word;
        bit          temp_bad;

        function new();
            errors    = 0;
            byte_pos  = POS_T_HI;
            crc_acc   = CRC_INIT;
            temp_word = '0;
            humi_word = '0;
            temp_bad  = 1'b0;
        endfunction

        // Serial form of the CRC-8: one data bit enters the feedback per shift.
        function bit [7:0] crc_over(input bit [7:0] crc, input bit [7:0] data);
            bit [7:0] acc;
            bit       fb;
            acc = crc;
            for (int i = 7; i >= 0; i--) begin
                fb  = acc[7] ^ data[i];
                acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return acc;
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Advances the frame state by one accepted byte; queues a reading on the sixth byte.
        function void note_byte(input bit [7:0] b, input bit frame_start);
            bit [2:0]    pos;
            t_reading    r;
            int unsigned scaled;
            pos = frame_start ? POS_T_HI : byte_pos;
            if (pos > POS_H_CRC) begin
                pos = POS_T_HI;
            end
            case (pos)
                POS_T_HI: begin
                    crc_acc   = crc_over(CRC_INIT, b);
                    temp_word = {b, 8'h00};
                    byte_pos  = POS_T_LO;
                end
                POS_T_LO: begin
                    crc_acc        = crc_over(crc_acc, b);
                    temp_word[7:0] = b;
                    byte_pos       = POS_T_CRC;
                end
                POS_T_CRC: begin
                    temp_bad = (crc_acc != b);
                    crc_acc  = CRC_INIT;
                    byte_pos = POS_H_HI;
                end
                POS_H_HI: begin
                    crc_acc   = crc_over(CRC_INIT, b);
                    humi_word = {b, 8'h00};
                    byte_pos  = POS_H_LO;
                end
                POS_H_LO: begin
                    crc_acc        = crc_over(crc_acc, b);
                    humi_word[7:0] = b;
                    byte_pos       = POS_H_CRC;
                end
                default: begin
                    // The temperature check wins when both words are corrupt.
                    if (temp_bad) begin
                        r.status = ST_TEMP_CRC;
                    end else if (crc_acc != b) begin
                        r.status = ST_HUMI_CRC;
                    end else begin
                        r.status = ST_OK;
                    end
                    r.temp_centi = '0;
                    r.humi_centi = '0;
                    if (r.status == ST_OK) begin
                        scaled       = (32'd17500 * temp_word) / 32'd65535;
                        r.temp_centi = 15'(scaled - 32'd4500);
                        scaled       = (32'd10000 * humi_word) / 32'd65535;
                        r.humi_centi = 14'(scaled);
                    end
                    pending_readings.push_back(r);
                    crc_acc  = CRC_INIT;
                    byte_pos = POS_T_HI;
                end
            endcase
        endfunction

        // Compares one accepted output word with the oldest owed reading.
        task check_reading(input logic [31:0] word);
            t_reading want;
            if (pending_readings.size() == 0) begin
                report($sformatf("reading %h arrived with no frame completed", word));
                return;
            end
            want = pending_readings.pop_front();
            if (word[1:0] !== want.status) begin
                report($sformatf("status %0d, want %0d", word[1:0], want.status));
            end
            if (word[16:2] !== want.temp_centi) begin
                report($sformatf("temperature %0d, want %0d",
                                 $signed(word[16:2]), $signed(want.temp_centi)));
            end
            if (word[30:17] !== want.humi_centi) begin
                report($sformatf("humidity %0d, want %0d", word[30:17], want.humi_centi));
            end
            if (word[31] !== 1'b0) begin
                report("padding bit of tdata is not zero");
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0; // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [1:0] status, [16:2] temperature_centi,
                                      // [30:17] humidity_centi, [31] zero

    reading_board sb = new();
    int           bytes_sent = 0;
    bit           steady = 1'b0;      // when set, neither side inserts idle cycles

    humidity_sensor_frame_decode dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Monitors: every transaction on either channel goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_byte(s_axis_tdata, s_axis_tuser);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_reading(m_axis_tdata);
        end
    end

    // Watchdog: the run is declared hung after a long stretch without any transaction.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: stalls a random number of cycles before taking each reading.
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Offers one byte after a random gap and returns at the edge it is accepted.
    task automatic send_byte(input bit [7:0] b, input bit frame_start);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= frame_start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Sends a complete six-byte frame, optionally corrupting either CRC byte.
    task automatic send_frame(input bit [15:0] raw_t, input bit [15:0] raw_h,
                              input bit bad_t, input bit bad_h, input bit frame_start);
        bit [7:0] crc_t;
        bit [7:0] crc_h;
        crc_t = sb.crc_over(sb.crc_over(CRC_INIT, raw_t[15:8]), raw_t[7:0]);
        crc_h = sb.crc_over(sb.crc_over(CRC_INIT, raw_h[15:8]), raw_h[7:0]);
        if (bad_t) begin
            crc_t ^= 8'($urandom_range(1, 255));
        end
        if (bad_h) begin
            crc_h ^= 8'($urandom_range(1, 255));
        end
        send_byte(raw_t[15:8], frame_start);
        send_byte(raw_t[7:0], 1'b0);
        send_byte(crc_t, 1'b0);
        send_byte(raw_h[15:8], 1'b0);
        send_byte(raw_h[7:0], 1'b0);
        send_byte(crc_h, 1'b0);
    endtask

    // Holds the sender off until every owed reading has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic bit [15:0] pick_raw();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Stimulus: directed frames first, then a random mix of frames and noise.
    initial begin
        int next_switch;
        int roll;
        int n;
        bit aligned;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A partial frame is dropped when a new frame starts in the middle.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1);
        // The position wraps after the sixth byte, so no start flag is needed here.
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        // Both CRCs corrupt: the temperature error is reported.
        send_frame(pick_raw(), pick_raw(), 1'b1, 1'b1, 1'b1);
        // Humidity CRC alone corrupt.
        send_frame(pick_raw(), pick_raw(), 1'b0, 1'b1, 1'b1);
        drain();

        aligned     = 1'b1;
        next_switch = bytes_sent;
        while (bytes_sent < TARGET_BYTES) begin
            if (bytes_sent >= next_switch) begin
                steady      = ($urandom_range(0, 3) == 0);
                next_switch = bytes_sent + 40;
            end
            roll = $urandom_range(0, 99);
            if (roll < 78) begin
                send_frame(pick_raw(), pick_raw(), $urandom_range(0, 7) == 0,
                           $urandom_range(0, 7) == 0,
                           aligned ? 1'($urandom_range(0, 1)) : 1'b1);
                aligned = 1'b1;
            end else if (roll < 88) begin
                // Truncated frame: one to five bytes, the first with a start flag.
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++) begin
                    send_byte(8'($urandom_range(0, 255)), k == 0);
                end
                aligned = 1'b0;
            end else if (roll < 97) begin
                // Loose bytes with random start flags.
                n = $urandom_range(1, 7);
                for (int k = 0; k < n; k++) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
                aligned = 1'b0;
            end else begin
                drain();
            end
        end

        // Wait for the last readings, then watch for anything extra.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/hsfd_pkg.sv
hw/rtl/hsfd_front.sv
hw/rtl/hsfd_fifo.sv
hw/rtl/hsfd_scale.sv
hw/rtl/humidity_sensor_frame_decode.sv
bench/tb.sv
